// ----- rtl/imurwmd_pkg.sv -----
// ============================================================================
// IMU rest window motion detector package
// Word types, register indexes, reset values and the window compare function.
// ============================================================================
`default_nettype none

package imurwmd_pkg;

    // Register indexes on the configuration port.
    localparam int unsigned CfgIndexWidth = 3;
    localparam int unsigned CfgDataWidth  = 15;

    typedef enum logic [CfgIndexWidth-1:0] {
        REG_ACCEL_MARGIN       = 3'd0,
        REG_GYRO_MARGIN_X      = 3'd1,
        REG_GYRO_MARGIN_Y      = 3'd2,
        REG_GYRO_MARGIN_Z_HIGH = 3'd3,
        REG_GYRO_MARGIN_Z_LOW  = 3'd4,
        REG_THEFT_COUNT        = 3'd5
    } cfg_reg_t;

    // Register reset values.
    localparam logic [14:0] AccelMarginReset     = 15'd300;
    localparam logic [14:0] GyroMarginXReset     = 15'd10;
    localparam logic [14:0] GyroMarginYReset     = 15'd12;
    localparam logic [14:0] GyroMarginZHighReset = 15'd9;
    localparam logic [14:0] GyroMarginZLowReset  = 15'd10;
    localparam logic [3:0]  TheftCountReset      = 4'd4;

    // One input word: a six-axis sample and the capture flag.
    typedef struct packed {
        logic               capture_rest;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
    } imu_in_t;

    // One result word.
    typedef struct packed {
        logic       accel_moved;
        logic       gyro_moved;
        logic       accel_theft;
        logic       gyro_theft;
        logic [3:0] accel_run;
        logic [3:0] gyro_run;
    } imu_out_t;

    // True when value lies outside [base - below, base + above]. The bounds
    // are formed at 18 bits so that they never wrap.
    function automatic logic window_outside(
        input logic signed [15:0] value,
        input logic signed [15:0] base,
        input logic        [14:0] above,
        input logic        [14:0] below
    );
        logic signed [17:0] value_w;
        logic signed [17:0] hi;
        logic signed [17:0] lo;
        value_w = 18'(value);
        hi      = 18'(base) + $signed({3'b000, above});
        lo      = 18'(base) - $signed({3'b000, below});
        return (value_w < lo) || (value_w > hi);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/imu_rest_window_motion_detector.sv -----
// ============================================================================
// IMU rest window motion detector
// Compares each six-axis sample against a stored rest baseline and counts
// consecutive out-of-window samples per sensor group to flag theft.
// ============================================================================
//
//  Channel   Ports                                   Direction  Word
//  input     s_valid, s_ready, s_data                in         imu_in_t
//  result    m_valid, m_ready, m_data                out        imu_out_t
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data  in      register write
//
// A word is registered at the input, evaluated from the input register once
// the result register is free, and its result is held in the result register.
// One word per cycle is sustained while m_ready stays high; the input
// register refills as the result register drains, so a stall at the result
// side backs up only two words. Reset (aresetn low, synchronous) restores
// register defaults, clears the baseline and run counters and empties both
// stages. Config writes are always accepted, as cfg_ready is tied high.
`default_nettype none

module imu_rest_window_motion_detector
    import imurwmd_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,

    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire imu_in_t                  s_data,

    output logic                          m_valid,
    input  wire logic                     m_ready,
    output imu_out_t                      m_data,

    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CfgIndexWidth-1:0] cfg_index,
    input  wire logic [CfgDataWidth-1:0]  cfg_data
);

    // Configuration registers.
    logic [14:0] accel_margin_reg;
    logic [14:0] gyro_margin_x_reg;
    logic [14:0] gyro_margin_y_reg;
    logic [14:0] gyro_margin_z_high_reg;
    logic [14:0] gyro_margin_z_low_reg;
    logic [3:0]  theft_count_reg;

    // Pipeline and state registers.
    logic        in_valid_reg;
    imu_in_t     in_data_reg;
    logic        out_valid_reg;
    imu_out_t    out_data_reg;
    imu_in_t     base_reg;
    logic [3:0]  accel_run_reg;
    logic [3:0]  gyro_run_reg;

    logic        advance;
    logic        accel_moved;
    logic        gyro_moved;
    logic        accel_theft;
    logic        gyro_theft;
    logic [3:0]  accel_run_next;
    logic [3:0]  gyro_run_next;
    logic [4:0]  accel_inc;
    logic [4:0]  gyro_inc;
    imu_out_t    out_data_next;

    assign cfg_ready = 1'b1;

    // Configuration writes; an unknown index is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accel_margin_reg       <= AccelMarginReset;
            gyro_margin_x_reg      <= GyroMarginXReset;
            gyro_margin_y_reg      <= GyroMarginYReset;
            gyro_margin_z_high_reg <= GyroMarginZHighReset;
            gyro_margin_z_low_reg  <= GyroMarginZLowReset;
            theft_count_reg        <= TheftCountReset;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ACCEL_MARGIN:       accel_margin_reg       <= cfg_data;
                REG_GYRO_MARGIN_X:      gyro_margin_x_reg      <= cfg_data;
                REG_GYRO_MARGIN_Y:      gyro_margin_y_reg      <= cfg_data;
                REG_GYRO_MARGIN_Z_HIGH: gyro_margin_z_high_reg <= cfg_data;
                REG_GYRO_MARGIN_Z_LOW:  gyro_margin_z_low_reg  <= cfg_data;
                REG_THEFT_COUNT:        theft_count_reg        <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Handshake: the input stage moves on when the result register is free.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // Window compares against the stored baseline.
    always_comb begin
        accel_moved =
            window_outside(in_data_reg.accel_x, base_reg.accel_x,
                           accel_margin_reg, accel_margin_reg) ||
            window_outside(in_data_reg.accel_y, base_reg.accel_y,
                           accel_margin_reg, accel_margin_reg) ||
            window_outside(in_data_reg.accel_z, base_reg.accel_z,
                           accel_margin_reg, accel_margin_reg);
        gyro_moved =
            window_outside(in_data_reg.gyro_x, base_reg.gyro_x,
                           gyro_margin_x_reg, gyro_margin_x_reg) ||
            window_outside(in_data_reg.gyro_y, base_reg.gyro_y,
                           gyro_margin_y_reg, gyro_margin_y_reg) ||
            window_outside(in_data_reg.gyro_z, base_reg.gyro_z,
                           gyro_margin_z_high_reg, gyro_margin_z_low_reg);
    end

    // Run counters: count on a miss, clear on a hit or on reaching theft, hold on a capture.
    always_comb begin
        accel_inc      = {1'b0, accel_run_reg} + 5'd1;
        gyro_inc       = {1'b0, gyro_run_reg} + 5'd1;
        accel_theft    = 1'b0;
        gyro_theft     = 1'b0;
        accel_run_next = accel_run_reg;
        gyro_run_next  = gyro_run_reg;
        if (!in_data_reg.capture_rest) begin
            if (!accel_moved) begin
                accel_run_next = 4'd0;
            end else if (accel_inc >= {1'b0, theft_count_reg}) begin
                accel_run_next = 4'd0;
                accel_theft    = 1'b1;
            end else begin
                accel_run_next = accel_inc[3:0];
            end
            if (!gyro_moved) begin
                gyro_run_next = 4'd0;
            end else if (gyro_inc >= {1'b0, theft_count_reg}) begin
                gyro_run_next = 4'd0;
                gyro_theft    = 1'b1;
            end else begin
                gyro_run_next = gyro_inc[3:0];
            end
        end
        out_data_next.accel_moved = accel_moved && !in_data_reg.capture_rest;
        out_data_next.gyro_moved  = gyro_moved && !in_data_reg.capture_rest;
        out_data_next.accel_theft = accel_theft;
        out_data_next.gyro_theft  = gyro_theft;
        out_data_next.accel_run   = accel_run_next;
        out_data_next.gyro_run    = gyro_run_next;
    end

    // Stage valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    // Baseline and run counter state, updated as a word is evaluated.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg      <= '0;
            accel_run_reg <= 4'd0;
            gyro_run_reg  <= 4'd0;
        end else if (advance) begin
            if (in_data_reg.capture_rest) begin
                base_reg <= in_data_reg;
            end
            accel_run_reg <= accel_run_next;
            gyro_run_reg  <= gyro_run_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/imurwmd_checker.sv -----
// ============================================================================
// IMU rest window motion detector checker
// Port-level checks on result words, bound to the top level.
// ============================================================================
`default_nettype none

module imurwmd_checker
    import imurwmd_pkg::*;
(
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire imu_out_t m_data
);

    // A stalled result word stays put.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // Theft always clears the run counter of its group.
    a_accel_theft_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.accel_theft |-> m_data.accel_run == 4'd0)
        else $error("accel theft without cleared run");

    a_gyro_theft_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.gyro_theft |-> m_data.gyro_run == 4'd0)
        else $error("gyro theft without cleared run");

    // Theft can only come from an out-of-window sample.
    a_accel_theft_moved: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.accel_theft |-> m_data.accel_moved)
        else $error("accel theft without movement");

    a_gyro_theft_moved: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.gyro_theft |-> m_data.gyro_moved)
        else $error("gyro theft without movement");

endmodule

bind imu_rest_window_motion_detector imurwmd_checker u_imurwmd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
